// ===== sv/max_heap_priority_queue_assert.svh =====
// Assertion macros for the priority queue.
`ifndef MAX_HEAP_PRIORITY_QUEUE_ASSERT_SVH
`define MAX_HEAP_PRIORITY_QUEUE_ASSERT_SVH

// Same-cycle implication, inactive while reset is asserted.
`define MHPQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, inactive while reset is asserted.
`define MHPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/mhpq_pkg.sv =====
`timescale 1ns / 1ps

package mhpq_pkg;

    localparam int KEY_W            = 32;
    localparam int STATUS_W         = 2;
    localparam int COUNT_OUT_W      = 6;
    localparam int DEFAULT_CAPACITY = 32;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

    // What a cell shows its neighbors.
    typedef struct packed {
        logic                    occ;   // cell holds an entry
        logic                    keep;  // on insert, cell keeps its entry (entry >= new key)
        logic signed [KEY_W-1:0] key;
    } cell_link_t;

    // Shift controls broadcast to every cell.
    typedef struct packed {
        logic ins;  // insert: entries below the new key move one cell down
        logic rem;  // remove: every entry moves one cell up
    } shift_ctl_t;

endpackage

// ===== sv/mhpq_cell.sv =====
`timescale 1ns / 1ps

module mhpq_cell (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  mhpq_pkg::shift_ctl_t                   ctl,
    input  logic signed [mhpq_pkg::KEY_W-1:0]      new_key,
    input  mhpq_pkg::cell_link_t                   up_link,
    input  mhpq_pkg::cell_link_t                   down_link,
    output mhpq_pkg::cell_link_t                   self_link
);
    import mhpq_pkg::*;

    logic                    occ_reg;
    logic                    occ_next;
    logic signed [KEY_W-1:0] key_reg;
    logic signed [KEY_W-1:0] key_next;
    logic                    keep;

    assign keep = occ_reg && !(new_key > key_reg);

    always_comb
    begin
        occ_next = occ_reg;
        key_next = key_reg;
        if (ctl.ins && !keep)
        begin
            if (up_link.keep)
            begin
                occ_next = 1'b1;
                key_next = new_key;
            end
            else
            begin
                occ_next = up_link.occ;
                key_next = up_link.key;
            end
        end
        else if (ctl.rem)
        begin
            occ_next = down_link.occ;
            key_next = down_link.key;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign self_link.occ  = occ_reg;
    assign self_link.keep = keep;
    assign self_link.key  = key_reg;

endmodule

// ===== sv/max_heap_priority_queue.sv =====
// Channel  | Handshake           | Payload
// ---------+---------------------+--------------------------------------
// in       | in_valid / in_ready | command, value
// out      | out_valid/out_ready | status, removed_max, entry_count
//
// One command per cycle while in_ready is high: every cell updates in parallel on a
// transfer and the result is registered in the next cycle, so commands stream back to back.
// Entries are kept sorted, largest in cell 1, so the maximum is always there.
// A new command is taken while the output register is empty or being drained.
// Reset empties every cell and clears the count; no clearing pass is needed.
`timescale 1ns / 1ps

module max_heap_priority_queue #(
    parameter int HEAP_CAPACITY = mhpq_pkg::DEFAULT_CAPACITY
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     in_valid,
    output logic                                     in_ready,
    input  logic                                     command,
    input  logic signed [mhpq_pkg::KEY_W-1:0]        value,
    output logic                                     out_valid,
    input  logic                                     out_ready,
    output logic [mhpq_pkg::STATUS_W-1:0]            status,
    output logic signed [mhpq_pkg::KEY_W-1:0]        removed_max,
    output logic [mhpq_pkg::COUNT_OUT_W-1:0]         entry_count
);
    import mhpq_pkg::*;

    localparam int CNT_W = $clog2(HEAP_CAPACITY + 1);

    logic                    take;
    logic                    full;
    logic                    empty;
    shift_ctl_t              ctl;
    cell_link_t              links [HEAP_CAPACITY+1:0];

    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic [CNT_W+COUNT_OUT_W-1:0] count_ext;

    logic                    out_valid_reg;
    logic [STATUS_W-1:0]     status_reg;
    logic [STATUS_W-1:0]     status_next;
    logic signed [KEY_W-1:0] removed_max_reg;
    logic signed [KEY_W-1:0] removed_max_next;
    logic [COUNT_OUT_W-1:0]  entry_count_reg;

    assign in_ready = !out_valid_reg || out_ready;
    assign take     = in_valid && in_ready;
    assign full     = count_reg == CNT_W'(HEAP_CAPACITY);
    assign empty    = count_reg == '0;

    assign ctl.ins = take && (command == CMD_INSERT) && !full;
    assign ctl.rem = take && (command == CMD_REMOVE) && !empty;

    // links[0] is a virtual cell above the root that always keeps;
    // links[HEAP_CAPACITY+1] is the empty slot below the last cell.
    assign links[0].occ  = 1'b1;
    assign links[0].keep = 1'b1;
    assign links[0].key  = '0;
    assign links[HEAP_CAPACITY+1].occ  = 1'b0;
    assign links[HEAP_CAPACITY+1].keep = 1'b0;
    assign links[HEAP_CAPACITY+1].key  = '0;

    for (genvar i = 1; i <= HEAP_CAPACITY; i++)
    begin : g_cell
        mhpq_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .new_key   (value),
            .up_link   (links[i-1]),
            .down_link (links[i+1]),
            .self_link (links[i])
        );
    end

    always_comb
    begin
        count_next       = count_reg;
        status_next      = ST_OK;
        removed_max_next = '0;
        if (command == CMD_INSERT)
        begin
            if (full)
                status_next = ST_OVERFLOW;
            else
                count_next = count_reg + 1'b1;
        end
        else
        begin
            if (empty)
                status_next = ST_UNDERFLOW;
            else
            begin
                count_next       = count_reg - 1'b1;
                removed_max_next = links[1].key;
            end
        end
    end

    assign count_ext = {{COUNT_OUT_W{1'b0}}, count_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            status_reg      <= status_next;
            removed_max_reg <= removed_max_next;
            entry_count_reg <= count_ext[COUNT_OUT_W-1:0];
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign removed_max = removed_max_reg;
    assign entry_count = entry_count_reg;

    `include "max_heap_priority_queue_assert.svh"

    `MHPQ_ASSERT_NOW(a_root_occ, 1'b1, links[1].occ == !empty, "root occupancy disagrees with count")
    `MHPQ_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(HEAP_CAPACITY), "count exceeds capacity")
    `MHPQ_ASSERT_NOW(a_sorted_top, links[1].occ && links[2].occ, links[1].key >= links[2].key, "top cells out of order")
    `MHPQ_ASSERT_NEXT(a_insert_count, ctl.ins, count_reg == $past(count_reg) + 1'b1, "insert did not grow count")
    `MHPQ_ASSERT_NEXT(a_fail_zero, take && (status_next != ST_OK), removed_max == '0, "failed command reported a key")

endmodule

// ===== tb/tb_max_heap_priority_queue.sv =====
`timescale 1ns / 1ps

module tb_max_heap_priority_queue;
    import mhpq_pkg::*;

    localparam int CAPACITY     = 32;
    localparam int RANDOM_ITEMS = 1750;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct {
        logic                    cmd;
        logic signed [KEY_W-1:0] key;
    } heap_cmd_t;

    typedef struct {
        logic [STATUS_W-1:0]     status;
        logic signed [KEY_W-1:0] removed_max;
        logic [COUNT_OUT_W-1:0]  entry_count;
    } heap_result_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic                    command = CMD_INSERT;
    logic signed [KEY_W-1:0] value = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic [STATUS_W-1:0]     status;
    logic signed [KEY_W-1:0] removed_max;
    logic [COUNT_OUT_W-1:0]  entry_count;

    max_heap_priority_queue #(.HEAP_CAPACITY(CAPACITY)) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .value       (value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .removed_max (removed_max),
        .entry_count (entry_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predicted heap contents
    logic signed [KEY_W-1:0] heap_q [CAPACITY];
    int                      heap_fill = 0;

    heap_cmd_t    pending_cmds [$];
    heap_result_t expected_results [$];

    int     n_total = 0;
    int     n_accepted = 0;
    int     mismatches = 0;
    int     idle_cycles = 0;
    int     shadow_fill = 0;
    bit     in_xfer = 1'b0;
    bit     out_xfer;
    int     in_gap = 0;
    int     out_stall = 0;
    bit     calm_in = 1'b0;
    bit     calm_out = 1'b0;
    int     cycle_ctr = 0;
    heap_cmd_t drv_item;

    function automatic heap_result_t heap_apply(logic cmd, logic signed [KEY_W-1:0] key);
        heap_result_t            r;
        int                      pos;
        int                      par;
        int                      best;
        int                      lc;
        bit                      done;
        logic signed [KEY_W-1:0] t;
        r.status      = ST_OK;
        r.removed_max = '0;
        if (cmd == CMD_INSERT)
        begin
            if (heap_fill >= CAPACITY)
                r.status = ST_OVERFLOW;
            else
            begin
                heap_q[heap_fill] = key;
                pos = heap_fill;
                heap_fill++;
                done = 1'b0;
                while (pos > 0 && !done)
                begin
                    par = (pos - 1) / 2;
                    if (heap_q[pos] > heap_q[par])
                    begin
                        t = heap_q[pos];
                        heap_q[pos] = heap_q[par];
                        heap_q[par] = t;
                        pos = par;
                    end
                    else
                        done = 1'b1;
                end
            end
        end
        else
        begin
            if (heap_fill == 0)
                r.status = ST_UNDERFLOW;
            else
            begin
                r.removed_max = heap_q[0];
                heap_fill--;
                heap_q[0] = heap_q[heap_fill];
                pos = 0;
                done = 1'b0;
                while (!done)
                begin
                    best = pos;
                    lc = 2 * pos + 1;
                    if (lc < heap_fill && heap_q[lc] > heap_q[best])
                        best = lc;
                    if (lc + 1 < heap_fill && heap_q[lc + 1] > heap_q[best])
                        best = lc + 1;
                    if (best == pos)
                        done = 1'b1;
                    else
                    begin
                        t = heap_q[pos];
                        heap_q[pos] = heap_q[best];
                        heap_q[best] = t;
                        pos = best;
                    end
                end
            end
        end
        r.entry_count = COUNT_OUT_W'(heap_fill);
        return r;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [KEY_W-1:0] pick_key();
        logic signed [KEY_W-1:0] k;
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 4))
                    0: k = 32'sh8000_0000;
                    1: k = 32'sh7fff_ffff;
                    2: k = 32'sd0;
                    3: k = -32'sd1;
                    default: k = 32'sd1;
                endcase
            end
            1, 2, 3: k = $signed($urandom_range(0, 8)) - 32'sd4;  // dense, many ties
            default: k = $urandom;
        endcase
        return k;
    endfunction

    task automatic queue_cmd(logic cmd, logic signed [KEY_W-1:0] key);
        heap_cmd_t c;
        c.cmd = cmd;
        c.key = key;
        pending_cmds.push_back(c);
        if (cmd == CMD_INSERT && shadow_fill < CAPACITY)
            shadow_fill++;
        else if (cmd == CMD_REMOVE && shadow_fill > 0)
            shadow_fill--;
    endtask

    // Stretches with no idling at all on either side
    always @(negedge clk)
    begin
        cycle_ctr <= cycle_ctr + 1;
        if (cycle_ctr % 256 == 0)
        begin
            calm_in  <= ($urandom_range(0, 3) == 0);
            calm_out <= ($urandom_range(0, 3) == 0);
        end
    end

    // Input driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_xfer)
            begin
                if (in_gap > 0)
                begin
                    in_valid <= 1'b0;
                    in_gap   <= in_gap - 1;
                end
                else if (pending_cmds.size() > 0)
                begin
                    drv_item = pending_cmds.pop_front();
                    command  <= drv_item.cmd;
                    value    <= drv_item.key;
                    in_valid <= 1'b1;
                    in_gap   <= calm_in ? 0 : idle_len();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Output backpressure
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_stall > 0)
            begin
                out_ready <= 1'b0;
                out_stall <= out_stall - 1;
            end
            else
            begin
                out_ready <= 1'b1;
                out_stall <= calm_out ? 0 : idle_len();
            end
        end
    end

    // Monitor, predictor and watchdog
    always @(posedge clk)
    begin
        heap_result_t want;
        in_xfer  = rst_n && in_valid && in_ready;
        out_xfer = rst_n && out_valid && out_ready;
        if (out_xfer)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result transfer with nothing expected: status %0d count %0d",
                       status, entry_count);
                mismatches++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    mismatches++;
                end
                if (removed_max !== want.removed_max)
                begin
                    $error("removed_max: expected %0d, got %0d", want.removed_max, removed_max);
                    mismatches++;
                end
                if (entry_count !== want.entry_count)
                begin
                    $error("entry_count: expected %0d, got %0d", want.entry_count, entry_count);
                    mismatches++;
                end
            end
        end
        if (in_xfer)
        begin
            expected_results.push_back(heap_apply(command, value));
            n_accepted++;
        end
        if (rst_n)
        begin
            if (in_xfer || out_xfer)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("FAIL max_heap_priority_queue");
                $finish;
            end
        end
    end

    initial
    begin
        int n_rand;
        int len;
        int bias;

        // Directed: underflow on empty, key extremes, ties, drain past empty
        queue_cmd(CMD_REMOVE, 32'sh1234_5678);
        queue_cmd(CMD_INSERT, 32'sh7fff_ffff);
        queue_cmd(CMD_INSERT, 32'sh8000_0000);
        queue_cmd(CMD_INSERT, 32'sd0);
        queue_cmd(CMD_INSERT, -32'sd1);
        queue_cmd(CMD_INSERT, 32'sd1);
        queue_cmd(CMD_INSERT, 32'sd5);
        queue_cmd(CMD_INSERT, 32'sd5);
        queue_cmd(CMD_INSERT, 32'sd5);
        for (int i = 0; i < 9; i++)
            queue_cmd(CMD_REMOVE, $urandom);

        // Random phases: fill to overflow, drain to underflow, or a biased mix
        n_rand = 0;
        while (n_rand < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    len = CAPACITY - shadow_fill + $urandom_range(1, 3);
                    for (int i = 0; i < len; i++)
                        queue_cmd(CMD_INSERT, pick_key());
                end
                1:
                begin
                    len = shadow_fill + $urandom_range(1, 2);
                    for (int i = 0; i < len; i++)
                        queue_cmd(CMD_REMOVE, $urandom);
                end
                default:
                begin
                    len  = $urandom_range(20, 60);
                    bias = $urandom_range(20, 80);
                    for (int i = 0; i < len; i++)
                    begin
                        if ($urandom_range(1, 100) <= bias)
                            queue_cmd(CMD_INSERT, pick_key());
                        else
                            queue_cmd(CMD_REMOVE, $urandom);
                    end
                end
            endcase
            n_rand += len;
        end
        n_total = pending_cmds.size();

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (n_accepted == n_total && expected_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("PASS max_heap_priority_queue");
        else
            $display("FAIL max_heap_priority_queue");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/mhpq_pkg.sv
sv/mhpq_cell.sv
sv/max_heap_priority_queue.sv
tb/tb_max_heap_priority_queue.sv
